// ===== sv/srg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srg_pkg: shared types and constants of the subtractive random generator
// Table geometry, modular constants, controller states and the command and
// status words between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package srg_pkg;

  localparam int unsigned WordW   = 30;
  localparam int unsigned SeedW   = 31;
  localparam int unsigned TableLen = 55;
  localparam int unsigned PtrW    = 6;

  localparam logic [WordW-1:0] ModBig   = 30'd1000000000;
  localparam logic [SeedW-1:0] SeedMix  = 31'd161803398;
  localparam logic [PtrW-1:0]  FillStride = 6'd21;
  localparam logic [PtrW-1:0]  LastSlot = 6'd55;
  localparam logic [PtrW-1:0]  LastFill = 6'd54;
  localparam logic [PtrW-1:0]  MixSplit = 6'd24;
  localparam logic [PtrW-1:0]  MixLag   = 6'd31;
  localparam logic [PtrW-1:0]  MixBack  = 6'd24;
  localparam logic [PtrW-1:0]  LeadReset = 6'd0;
  localparam logic [PtrW-1:0]  LagReset  = 6'd31;
  localparam logic [1:0]       LastPass  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEED_INIT,
    ST_FILL,
    ST_MIX_RD,
    ST_MIX_WR,
    ST_DRAW_RD,
    ST_DRAW_WR
  } srg_state_e;

  typedef struct packed {
    logic seed_init;
    logic fill_step;
    logic mix_rd;
    logic mix_wr;
    logic draw_rd;
    logic draw_wr;
  } srg_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic mix_last;
  } srg_sts_t;

  // a - b wrapped into [0, 1e9) for operands already in that range.
  function automatic logic [WordW-1:0] sub_wrap(input logic [WordW-1:0] a,
                                                input logic [WordW-1:0] b);
    logic [WordW:0] t;
    t = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      t = t + {1'b0, ModBig};
    end
    return t[WordW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/srg_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srg_ram: generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_a_i,
  input  wire logic [AddrW-1:0] raddr_b_i,
  output logic      [Width-1:0] rdata_a_o,
  output logic      [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ===== sv/srg_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srg_datapath: table, pointers and arithmetic of the generator
// Holds the seed register, the seeding recurrence, warm-up indices, draw
// pointers, the table RAM and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        seed_value_we_i,
  input  wire logic [srg_pkg::SeedW-1:0]   seed_value_i,
  input  wire srg_pkg::srg_cmd_t           cmd_i,
  output srg_pkg::srg_sts_t                sts_o,
  output logic                             result_valid_o,
  output logic      [srg_pkg::WordW-1:0]   random_value_o
);

  localparam int unsigned PW = srg_pkg::PtrW;
  localparam int unsigned WW = srg_pkg::WordW;
  localparam int unsigned SW = srg_pkg::SeedW;

  logic [SW-1:0] seed_q;
  logic [WW-1:0] j_q, k_q;
  logic [PW-1:0] slot_q, fill_cnt_q;
  logic [PW-1:0] mix_i_q;
  logic [1:0]    pass_q;
  logic [PW-1:0] lead_q, lag_q;
  logic          valid_q;
  logic [WW-1:0] value_q;

  logic [SW-1:0] seed_diff;
  logic [SW-1:0] seed_red;
  logic [WW-1:0] j_init;
  logic [PW:0]   slot_sum;
  logic [PW-1:0] slot_nx;
  logic [PW-1:0] mix_partner;
  logic [PW-1:0] lead_nx, lag_nx;

  logic          ram_we;
  logic [PW-1:0] ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [WW-1:0] ram_wdata, ram_rdata_a, ram_rdata_b;
  logic [WW-1:0] diff;

  // Seed folding: |mix - seed| is below twice the modulus, one subtract suffices.
  always_comb begin
    seed_diff = (seed_q >= srg_pkg::SeedMix) ? (seed_q - srg_pkg::SeedMix)
                                             : (srg_pkg::SeedMix - seed_q);
    seed_red  = seed_diff;
    if (seed_diff >= {1'b0, srg_pkg::ModBig}) begin
      seed_red = seed_diff - {1'b0, srg_pkg::ModBig};
    end
    j_init = seed_red[WW-1:0];
  end

  // The stride sum can reach 75, so it carries one extra bit.
  always_comb begin
    slot_sum = {1'b0, slot_q} + {1'b0, srg_pkg::FillStride};
    slot_nx  = (slot_sum >= {1'b0, srg_pkg::LastSlot})
             ? PW'(slot_sum - {1'b0, srg_pkg::LastSlot})
             : slot_sum[PW-1:0];
    mix_partner = (mix_i_q <= srg_pkg::MixSplit) ? (mix_i_q + srg_pkg::MixLag)
                                                 : (mix_i_q - srg_pkg::MixBack);
    lead_nx = (lead_q >= srg_pkg::LastSlot) ? PW'(1) : (lead_q + PW'(1));
    lag_nx  = (lag_q >= srg_pkg::LastSlot) ? PW'(1) : (lag_q + PW'(1));
  end

  assign diff = srg_pkg::sub_wrap(ram_rdata_a, ram_rdata_b);

  // Table slots run 1..55; RAM addresses are one lower.
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = srg_pkg::LastSlot - PW'(1);
    ram_wdata   = j_init;
    ram_raddr_a = mix_i_q - PW'(1);
    ram_raddr_b = mix_partner - PW'(1);
    if (cmd_i.draw_rd) begin
      ram_raddr_a = lead_nx - PW'(1);
      ram_raddr_b = lag_nx - PW'(1);
    end
    if (cmd_i.seed_init) begin
      ram_we = 1'b1;
    end else if (cmd_i.fill_step) begin
      ram_we    = 1'b1;
      ram_waddr = slot_q - PW'(1);
      ram_wdata = k_q;
    end else if (cmd_i.mix_wr) begin
      ram_we    = 1'b1;
      ram_waddr = mix_i_q - PW'(1);
      ram_wdata = diff;
    end else if (cmd_i.draw_wr) begin
      ram_we    = 1'b1;
      ram_waddr = lead_q - PW'(1);
      ram_wdata = diff;
    end
  end

  srg_ram #(
    .Width (WW),
    .Depth (srg_pkg::TableLen)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (ram_raddr_a),
    .raddr_b_i (ram_raddr_b),
    .rdata_a_o (ram_rdata_a),
    .rdata_b_o (ram_rdata_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q  <= '0;
      lead_q  <= srg_pkg::LeadReset;
      lag_q   <= srg_pkg::LagReset;
      valid_q <= 1'b0;
    end else begin
      if (seed_value_we_i) begin
        seed_q <= seed_value_i;
      end
      if (cmd_i.seed_init) begin
        lead_q <= srg_pkg::LeadReset;
        lag_q  <= srg_pkg::LagReset;
      end else if (cmd_i.draw_rd) begin
        lead_q <= lead_nx;
        lag_q  <= lag_nx;
      end
      valid_q <= cmd_i.draw_wr;
    end
  end

  // Recurrence and index registers; every field is loaded before it is used.
  always_ff @(posedge clk_i) begin
    if (cmd_i.seed_init) begin
      j_q        <= j_init;
      k_q        <= WW'(1);
      slot_q     <= srg_pkg::FillStride;
      fill_cnt_q <= PW'(1);
      mix_i_q    <= PW'(1);
      pass_q     <= '0;
    end
    if (cmd_i.fill_step) begin
      j_q        <= k_q;
      k_q        <= srg_pkg::sub_wrap(j_q, k_q);
      slot_q     <= slot_nx;
      fill_cnt_q <= fill_cnt_q + PW'(1);
    end
    if (cmd_i.mix_wr) begin
      if (mix_i_q == srg_pkg::LastSlot) begin
        mix_i_q <= PW'(1);
        pass_q  <= pass_q + 2'd1;
      end else begin
        mix_i_q <= mix_i_q + PW'(1);
      end
    end
    if (cmd_i.draw_wr) begin
      value_q <= diff;
    end
  end

  assign sts_o.fill_last = (fill_cnt_q == srg_pkg::LastFill);
  assign sts_o.mix_last  = (mix_i_q == srg_pkg::LastSlot) && (pass_q == srg_pkg::LastPass);

  assign result_valid_o = valid_q;
  assign random_value_o = value_q;

endmodule

`default_nettype wire

// ===== sv/srg_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srg_ctrl: sequencer of the generator
// Steps through seeding, warm-up passes and draws, and issues datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic              reseed_i,
  input  wire srg_pkg::srg_sts_t sts_i,
  output srg_pkg::srg_cmd_t      cmd_o,
  output logic                   busy
);

  srg_pkg::srg_state_e state_q, state_d;
  logic seeded_q, seeded_d;
  logic accept;

  assign accept = start && (state_q == srg_pkg::ST_IDLE);

  always_comb begin
    state_d  = state_q;
    seeded_d = seeded_q;
    case (state_q)
      srg_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (reseed_i || !seeded_q) ? srg_pkg::ST_SEED_INIT : srg_pkg::ST_DRAW_WR;
        end
      end
      srg_pkg::ST_SEED_INIT: state_d = srg_pkg::ST_FILL;
      srg_pkg::ST_FILL: begin
        if (sts_i.fill_last) begin
          state_d = srg_pkg::ST_MIX_RD;
        end
      end
      srg_pkg::ST_MIX_RD: state_d = srg_pkg::ST_MIX_WR;
      srg_pkg::ST_MIX_WR: begin
        if (sts_i.mix_last) begin
          state_d  = srg_pkg::ST_DRAW_RD;
          seeded_d = 1'b1;
        end else begin
          state_d = srg_pkg::ST_MIX_RD;
        end
      end
      srg_pkg::ST_DRAW_RD: state_d = srg_pkg::ST_DRAW_WR;
      srg_pkg::ST_DRAW_WR: state_d = srg_pkg::ST_IDLE;
      default:             state_d = srg_pkg::ST_IDLE;
    endcase
  end

  // A draw on a seeded table issues its reads in the accepting cycle.
  always_comb begin
    cmd_o = '0;
    busy  = 1'b1;
    case (state_q)
      srg_pkg::ST_IDLE: begin
        busy          = 1'b0;
        cmd_o.draw_rd = accept && seeded_q && !reseed_i;
      end
      srg_pkg::ST_SEED_INIT: cmd_o.seed_init = 1'b1;
      srg_pkg::ST_FILL:      cmd_o.fill_step = 1'b1;
      srg_pkg::ST_MIX_RD:    cmd_o.mix_rd    = 1'b1;
      srg_pkg::ST_MIX_WR:    cmd_o.mix_wr    = 1'b1;
      srg_pkg::ST_DRAW_RD:   cmd_o.draw_rd   = 1'b1;
      srg_pkg::ST_DRAW_WR:   cmd_o.draw_wr   = 1'b1;
      default:               cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= srg_pkg::ST_IDLE;
      seeded_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      seeded_q <= seeded_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/subtractive_random_generator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtractive_random_generator_top: lagged subtractive random generator
// 55-word table modulo 1e9; each request returns one word in [0, 999999999].
//
// Channel   Ports                            Transfer
// request   start, busy, reseed_i            start high while busy low
// result    result_valid_o, random_value_o   one-cycle strobe
// config    seed_value_we_i, seed_value_i    write enable, no wait
//
// A draw on a seeded table reads both words from the table RAM in the accepting
// cycle, then writes back the difference, which is also registered as the result.
// A reseed, or the first request after reset, folds the seed, makes 54 fill
// writes and 220 warm-up steps of a read and a write on the RAM port, then draws.
// Reset leaves the table unseeded; the strobe cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module subtractive_random_generator_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      reseed_i,
  input  wire logic                      seed_value_we_i,
  input  wire logic [srg_pkg::SeedW-1:0] seed_value_i,
  output logic                           result_valid_o,
  output logic      [srg_pkg::WordW-1:0] random_value_o
);

  srg_pkg::srg_cmd_t cmd;
  srg_pkg::srg_sts_t sts;

  srg_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .reseed_i (reseed_i),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .busy     (busy)
  );

  srg_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .seed_value_we_i (seed_value_we_i),
    .seed_value_i    (seed_value_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .result_valid_o  (result_valid_o),
    .random_value_o  (random_value_o)
  );

endmodule

`default_nettype wire

// ===== sv/srg_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srg_checker: port-level checks of the generator
// Watches the request and result ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srg_checker (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      result_valid_o,
  input wire logic [srg_pkg::WordW-1:0] random_value_o
);

  // An accepted word always makes the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  // Every word that finishes is delivered as busy falls.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> result_valid_o)
    else $error("busy fell without a result strobe");

  // A result strobe comes only once the block is free again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobe while busy");

  // A delivered word lies below the modulus.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (random_value_o < srg_pkg::ModBig))
    else $error("result word out of range");

endmodule

bind subtractive_random_generator_top srg_checker u_srg_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .random_value_o (random_value_o)
);

`default_nettype wire
